// File: hdl/dpce_pkg.sv
// Shared types, constants and handshake structs for the delta patch command encoder.
package dpce_pkg;

   localparam int POS_W       = 31;
   localparam int MAX_PENDING = 32;
   localparam int PEND_DEPTH  = 32;
   localparam int PEND_AW     = $clog2(PEND_DEPTH);
   localparam int COUNT_W     = PEND_AW + 1;
   localparam int VAR_W       = POS_W + 2;

   localparam logic [1:0] KIND_SOURCE_READ = 2'd0;
   localparam logic [1:0] KIND_TARGET_READ = 2'd1;
   localparam logic [1:0] KIND_SOURCE_COPY = 2'd2;
   localparam logic [1:0] KIND_TARGET_COPY = 2'd3;

   localparam logic OP_OFFER  = 1'b0;
   localparam logic OP_FINISH = 1'b1;

   typedef struct packed {
      logic             op;
      logic             from_target;
      logic [POS_W-1:0] match_pos;
      logic [POS_W-1:0] span_len;
      logic [7:0]       literal;
   } req_type;

   typedef struct packed {
      logic [7:0]       out_byte;
      logic             byte_valid;
      logic [POS_W-1:0] consumed;
      logic             last;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_LIT_CMD,
      ST_LIT_BYTE,
      ST_CMD,
      ST_DELTA,
      ST_NONE
   } state_type;

   typedef enum logic [1:0] {
      SEL_NONE,
      SEL_LIT_CMD,
      SEL_LIT_BYTE,
      SEL_VARINT
   } sel_type;

   typedef struct packed {
      logic    latch_req;
      logic    push_lit;
      logic    take_match;
      logic    emit;
      sel_type sel;
      logic    last;
      logic    lit_step;
      logic    clear_pend;
      logic    load_delta;
   } ctrl_cmd_type;

   typedef struct packed {
      logic is_finish;
      logic take;
      logic pend_nz;
      logic pend_full_next;
      logic lit_final;
      logic var_final;
      logic has_copy;
      logic has_delta;
      logic out_free;
   } ctrl_status_type;

endpackage

// File: hdl/dpce_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dpce_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/dpce_ctrl.sv
// Sequencer: evaluates each request and steps through literal flush and varint emission.
module dpce_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  dpce_pkg::ctrl_status_type status,
   output dpce_pkg::ctrl_cmd_type    cmd
);
   import dpce_pkg::*;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_EVAL;
         end
         ST_EVAL: begin
            if (status.is_finish) begin
               state_in = status.pend_nz ? ST_LIT_CMD : ST_NONE;
            end else if (!status.take) begin
               state_in = status.pend_full_next ? ST_LIT_CMD : ST_NONE;
            end else begin
               state_in = status.pend_nz ? ST_LIT_CMD : ST_CMD;
            end
         end
         ST_LIT_CMD: begin
            if (status.out_free) state_in = ST_LIT_BYTE;
         end
         ST_LIT_BYTE: begin
            if (status.out_free && status.lit_final) begin
               state_in = status.has_copy ? ST_CMD : ST_IDLE;
            end
         end
         ST_CMD: begin
            if (status.out_free && status.var_final) begin
               state_in = status.has_delta ? ST_DELTA : ST_IDLE;
            end
         end
         ST_DELTA: begin
            if (status.out_free && status.var_final) state_in = ST_IDLE;
         end
         ST_NONE: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      cmd.sel   = SEL_NONE;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready     = 1'b1;
            cmd.latch_req = req_valid;
         end
         ST_EVAL: begin
            if (!status.is_finish) begin
               cmd.push_lit   = !status.take;
               cmd.take_match = status.take;
            end
         end
         ST_LIT_CMD: begin
            cmd.emit = status.out_free;
            cmd.sel  = SEL_LIT_CMD;
         end
         ST_LIT_BYTE: begin
            cmd.emit       = status.out_free;
            cmd.sel        = SEL_LIT_BYTE;
            cmd.lit_step   = status.out_free;
            cmd.clear_pend = status.out_free && status.lit_final;
            cmd.last       = status.lit_final && !status.has_copy;
         end
         ST_CMD: begin
            cmd.emit       = status.out_free;
            cmd.sel        = SEL_VARINT;
            cmd.last       = status.var_final && !status.has_delta;
            cmd.load_delta = status.out_free && status.var_final && status.has_delta;
         end
         ST_DELTA: begin
            cmd.emit = status.out_free;
            cmd.sel  = SEL_VARINT;
            cmd.last = status.var_final;
         end
         ST_NONE: begin
            cmd.emit = status.out_free;
            cmd.sel  = SEL_NONE;
            cmd.last = 1'b1;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // every request ends with exactly one last transfer, after which we are idle
   a_last_to_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && cmd.last) |=> (state_ff == ST_IDLE))
      else $error("last transfer did not return to idle");

   a_accept_to_eval: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_EVAL))
      else $error("accepted request not evaluated");

   a_no_emit_when_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> status.out_free)
      else $error("emit while output register is occupied");

endmodule

// File: hdl/dpce_datapath.sv
// Datapath: cost estimate, position and cursor registers, literal buffer, varint engine.
module dpce_datapath (
   input  logic                      clock,
   input  logic                      reset,
   input  dpce_pkg::req_type         req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output dpce_pkg::rsp_type         rsp_data,
   input  dpce_pkg::ctrl_cmd_type    cmd,
   output dpce_pkg::ctrl_status_type status
);
   import dpce_pkg::*;

   function automatic logic [2:0] varint_size(input logic [POS_W-1:0] v);
      logic [2:0] n;
      if (v[POS_W-1:7] == '0)       n = 3'd1;
      else if (v[POS_W-1:14] == '0) n = 3'd2;
      else if (v[POS_W-1:21] == '0) n = 3'd3;
      else if (v[POS_W-1:28] == '0) n = 3'd4;
      else                          n = 3'd5;
      return n;
   endfunction

   req_type            req_ff, req_in;
   logic [POS_W-1:0]   opos_ff, opos_in;
   logic [POS_W-1:0]   scur_ff, scur_in;
   logic [POS_W-1:0]   tcur_ff, tcur_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [PEND_AW-1:0] idx_ff, idx_in;
   logic [VAR_W-1:0]   var_ff, var_in;
   logic [VAR_W-1:0]   delta_ff, delta_in;
   logic [POS_W-1:0]   consumed_ff, consumed_in;
   logic               has_copy_ff, has_copy_in;
   logic               has_delta_ff, has_delta_in;
   rsp_type            rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic               sread;
   logic [POS_W-1:0]   cur;
   logic               pos_lt;
   logic [POS_W-1:0]   pos_diff;
   logic [3:0]         cost;
   logic [3:0]         need;
   logic               take;
   logic [1:0]         kind;
   logic [VAR_W-1:0]   cmd_val;
   logic [VAR_W-1:0]   delta_val;
   logic [POS_W-1:0]   new_cur;
   logic               var_big;
   logic [7:0]         var_byte;
   logic [VAR_W-1:0]   var_next;
   logic [COUNT_W-1:0] count_m1;
   logic [7:0]         lit_cmd_byte;
   logic [7:0]         sel_byte;
   logic               out_free;
   logic [PEND_AW-1:0] rd_addr;
   logic [7:0]         rd_data;

   // offer evaluation
   always_comb begin
      sread    = !req_ff.from_target && (req_ff.match_pos == opos_ff);
      cur      = req_ff.from_target ? tcur_ff : scur_ff;
      pos_lt   = req_ff.match_pos < cur;
      pos_diff = pos_lt ? (cur - req_ff.match_pos) : (req_ff.match_pos - cur);
      cost     = sread ? 4'd1 : ({1'b0, varint_size(pos_diff)} + 4'd1);
      need     = 4'd1 + cost + {3'b0, (count_ff != '0)}
                 + {3'b0, (req_ff.span_len == POS_W'(1))};
      take     = req_ff.span_len >= POS_W'(need);
      if (sread)                   kind = KIND_SOURCE_READ;
      else if (req_ff.from_target) kind = KIND_TARGET_COPY;
      else                         kind = KIND_SOURCE_COPY;
      cmd_val   = {req_ff.span_len - POS_W'(1), kind};
      delta_val = {1'b0, pos_diff, pos_lt};
      new_cur   = req_ff.match_pos + req_ff.span_len;
   end

   // bijective base-128 varint step
   always_comb begin
      var_big  = |var_ff[VAR_W-1:7];
      var_byte = {~var_big, var_ff[6:0]};
      var_next = (var_ff >> 7) - VAR_W'(1);
      count_m1 = count_ff - COUNT_W'(1);
      lit_cmd_byte = {1'b1, count_m1[PEND_AW-1:0], KIND_TARGET_READ};
   end

   assign out_free = !rsp_valid_ff || rsp_ready;

   // prefetch one entry ahead so the literal run goes out one byte a cycle while the output register is free
   assign rd_addr = cmd.lit_step ? (idx_ff + PEND_AW'(1)) : idx_ff;

   dpce_ram #(
      .WIDTH (8),
      .DEPTH (PEND_DEPTH)
   ) u_pend_ram (
      .clock   (clock),
      .wr_en   (cmd.push_lit),
      .wr_addr (count_ff[PEND_AW-1:0]),
      .wr_data (req_ff.literal),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      case (cmd.sel)
         SEL_LIT_CMD:  sel_byte = lit_cmd_byte;
         SEL_LIT_BYTE: sel_byte = rd_data;
         SEL_VARINT:   sel_byte = var_byte;
         default:      sel_byte = 8'h00;
      endcase
   end

   always_comb begin
      req_in       = req_ff;
      opos_in      = opos_ff;
      scur_in      = scur_ff;
      tcur_in      = tcur_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      var_in       = var_ff;
      delta_in     = delta_ff;
      consumed_in  = consumed_ff;
      has_copy_in  = has_copy_ff;
      has_delta_in = has_delta_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      if (cmd.latch_req) begin
         req_in       = req_data;
         consumed_in  = '0;
         has_copy_in  = 1'b0;
         has_delta_in = 1'b0;
         idx_in       = '0;
      end
      if (cmd.push_lit) begin
         count_in    = count_ff + COUNT_W'(1);
         opos_in     = opos_ff + POS_W'(1);
         consumed_in = POS_W'(1);
      end
      if (cmd.take_match) begin
         opos_in      = opos_ff + req_ff.span_len;
         var_in       = cmd_val;
         delta_in     = delta_val;
         consumed_in  = req_ff.span_len;
         has_copy_in  = 1'b1;
         has_delta_in = !sread;
         if (!sread && req_ff.from_target) tcur_in = new_cur;
         if (!sread && !req_ff.from_target) scur_in = new_cur;
      end
      if (cmd.lit_step) idx_in = idx_ff + PEND_AW'(1);
      if (cmd.clear_pend) begin
         count_in = '0;
         idx_in   = '0;
      end
      if (cmd.emit && cmd.sel == SEL_VARINT) var_in = var_next;
      if (cmd.load_delta) var_in = delta_ff;
      if (cmd.emit) begin
         rsp_valid_in      = 1'b1;
         rsp_in.out_byte   = sel_byte;
         rsp_in.byte_valid = (cmd.sel != SEL_NONE);
         rsp_in.consumed   = cmd.last ? consumed_ff : '0;
         rsp_in.last       = cmd.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         opos_ff      <= '0;
         scur_ff      <= '0;
         tcur_ff      <= '0;
         count_ff     <= '0;
         idx_ff       <= '0;
         has_copy_ff  <= 1'b0;
         has_delta_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         opos_ff      <= opos_in;
         scur_ff      <= scur_in;
         tcur_ff      <= tcur_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         has_copy_ff  <= has_copy_in;
         has_delta_ff <= has_delta_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff      <= req_in;
      var_ff      <= var_in;
      delta_ff    <= delta_in;
      consumed_ff <= consumed_in;
      rsp_ff      <= rsp_in;
   end

   always_comb begin
      status.is_finish      = (req_ff.op == OP_FINISH);
      status.take           = take;
      status.pend_nz        = (count_ff != '0);
      status.pend_full_next = (count_ff + COUNT_W'(1)) >= COUNT_W'(MAX_PENDING);
      status.lit_final      = (COUNT_W'(idx_ff) == count_m1);
      status.var_final      = !var_big;
      status.has_copy       = has_copy_ff;
      status.has_delta      = has_delta_ff;
      status.out_free       = out_free;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(MAX_PENDING))
      else $error("literal buffer count out of range");

   // a full buffer must be drained before another literal comes in
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      cmd.push_lit |-> (count_ff < COUNT_W'(MAX_PENDING)))
      else $error("literal pushed into a full buffer");

   a_flush_nonempty: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && cmd.sel == SEL_LIT_CMD) |-> (count_ff != '0))
      else $error("TargetRead command with empty literal buffer");

endmodule

// File: hdl/delta_patch_command_encoder.sv
// Top level of the delta patch command encoder.
// Takes one request at a time: a match offer or a finish. An offer that emits no
// patch bytes goes from its transfer through accept and evaluate to its single result;
// an item that emits bytes sends them one byte per cycle out of the output register as
// long as rsp_ready stays high. A literal flush is one TargetRead command byte followed
// by up to 32 buffered bytes, read one ahead from a buffer RAM with registered read
// data; a copy command and its delta are bijective base-128 varints of up to five bytes
// each, produced one byte a cycle while the output register is free, by a
// shift-and-decrement step. The next request is taken in the cycle after the last
// result of the previous one has been loaded into the output register.
module delta_patch_command_encoder (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  dpce_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output dpce_pkg::rsp_type rsp_data
);
   import dpce_pkg::*;

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   dpce_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   dpce_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .status    (status)
   );

endmodule
